### rtl/bfp_pkg.sv
package bfp_pkg;

  // Fixed widths of the channel payload fields.
  localparam int OP_W        = 2;
  localparam int REQ_W       = 40;
  localparam int IDX_OUT_W   = 6;
  localparam int STATUS_W    = 2;
  localparam int BYTES_OUT_W = 41;
  localparam int TOTAL_W     = 47;

  // Default configuration of the pool.
  localparam int POOL_ENTRIES_DEF = 64;
  localparam int SIZE_BITS_DEF    = 40;
  localparam int ALIGN_BYTES_DEF  = 256;

  // Growth factor 1.05 is taken as 21/20, that is req + floor(req / 20).
  localparam int GROW_DEN = 20;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_CLEAR   = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_REUSED   = 2'd0,
    ST_APPENDED = 2'd1,
    ST_FULL     = 2'd2,
    ST_DONE     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CMT_REUSE,
    CMT_APPEND,
    CMT_FULL,
    CMT_RELEASE,
    CMT_CLEAR,
    CMT_NONE
  } commit_t;

  typedef struct packed {
    logic    start;
    logic    commit;
    commit_t kind;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic size_done;
    logic found;
    logic pool_full;
  } dp_status_t;

endpackage

### rtl/bfp_in_if.sv
interface bfp_in_if;
  logic                        valid;
  logic                        ready;
  logic [bfp_pkg::OP_W-1:0]    operation;
  logic [bfp_pkg::REQ_W-1:0]   request_bytes;

  modport source (output valid, output operation, output request_bytes, input ready);
  modport sink   (input valid, input operation, input request_bytes, output ready);
endinterface

### rtl/bfp_out_if.sv
interface bfp_out_if;
  logic                             valid;
  logic                             ready;
  logic [bfp_pkg::IDX_OUT_W-1:0]    entry_index;
  logic [bfp_pkg::STATUS_W-1:0]     status;
  logic [bfp_pkg::BYTES_OUT_W-1:0]  entry_bytes;
  logic [bfp_pkg::TOTAL_W-1:0]      total_bytes;

  modport source (output valid, output entry_index, output status, output entry_bytes,
                  output total_bytes, input ready);
  modport sink   (input valid, input entry_index, input status, input entry_bytes,
                  input total_bytes, output ready);
endinterface

### rtl/bfp_ctrl.sv
module bfp_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic [bfp_pkg::OP_W-1:0] in_op,
  output logic                     in_ready,
  output logic                     out_valid,
  input  logic                     out_ready,
  output bfp_pkg::ctrl_cmd_t       cmd,
  input  bfp_pkg::dp_status_t      sts
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_COMMIT
  } state_t;

  state_t             state_r;
  bfp_pkg::commit_t   kind_r;
  logic               out_valid_r;
  logic               commit_ok;

  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  // The result register may be loaded once the previous result has left.
  assign commit_ok  = (state_r == S_COMMIT) && (!out_valid_r || out_ready);

  assign cmd.start  = in_ready && in_valid && (bfp_pkg::op_t'(in_op) == bfp_pkg::OP_ALLOC);
  assign cmd.commit = commit_ok;
  assign cmd.kind   = kind_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      kind_r      <= bfp_pkg::CMT_NONE;
      out_valid_r <= 1'b0;
    end else begin
      if (commit_ok) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            unique case (bfp_pkg::op_t'(in_op))
              bfp_pkg::OP_ALLOC: begin
                state_r <= S_SEARCH;
              end
              bfp_pkg::OP_RELEASE: begin
                kind_r  <= bfp_pkg::CMT_RELEASE;
                state_r <= S_COMMIT;
              end
              bfp_pkg::OP_CLEAR: begin
                kind_r  <= bfp_pkg::CMT_CLEAR;
                state_r <= S_COMMIT;
              end
              bfp_pkg::OP_NONE: begin
                kind_r  <= bfp_pkg::CMT_NONE;
                state_r <= S_COMMIT;
              end
            endcase
          end
        end
        S_SEARCH: begin
          if (sts.scan_done && sts.size_done) begin
            priority if (sts.found) begin
              kind_r <= bfp_pkg::CMT_REUSE;
            end else if (sts.pool_full) begin
              kind_r <= bfp_pkg::CMT_FULL;
            end else begin
              kind_r <= bfp_pkg::CMT_APPEND;
            end
            state_r <= S_COMMIT;
          end
        end
        S_COMMIT: begin
          if (commit_ok) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/bfp_grow.sv
module bfp_grow #(
  parameter int SIZE_BITS   = bfp_pkg::SIZE_BITS_DEF,
  parameter int ALIGN_BYTES = bfp_pkg::ALIGN_BYTES_DEF,
  parameter int ENTRY_W     = bfp_pkg::SIZE_BITS_DEF + 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [SIZE_BITS-1:0] req,
  output logic               done,
  output logic [ENTRY_W-1:0] grown
);

  // Three passes over one slice multiplier, one operand slice per cycle:
  // q = floor(req / 20) by reciprocal, then ceil(adj / A) by reciprocal,
  // then the quotient times A.
  localparam int DEN   = bfp_pkg::GROW_DEN;
  localparam int CH    = 16;
  localparam int NCH   = (ENTRY_W + CH - 1) / CH;
  localparam int XW    = NCH * CH;
  localparam int KW    = ENTRY_W + 2;
  localparam int PW    = XW + KW;
  localparam int MW    = CH + KW;
  localparam int CNT_W = $clog2(NCH + 1);
  localparam int SH1   = SIZE_BITS + $clog2(DEN);
  localparam int SH2   = ENTRY_W + $clog2(ALIGN_BYTES);
  localparam logic [127:0] M1_FULL =
    ((128'd1 << SH1) + 128'(DEN - 1)) / 128'(DEN);
  localparam logic [127:0] M2_FULL =
    ((128'd1 << SH2) + 128'(ALIGN_BYTES - 1)) / 128'(ALIGN_BYTES);
  localparam logic [KW-1:0]      M1       = KW'(M1_FULL);
  localparam logic [KW-1:0]      M2       = KW'(M2_FULL);
  localparam logic [KW-1:0]      ALIGN_K  = KW'(ALIGN_BYTES);
  localparam logic [ENTRY_W-1:0] ALIGN_M1 = ENTRY_W'(ALIGN_BYTES - 1);
  localparam logic [CNT_W-1:0]   LAST_CNT = CNT_W'(NCH - 1);

  typedef enum logic [1:0] {
    G_IDLE,
    G_MUL,
    G_STEP,
    G_DONE
  } gstate_t;

  typedef enum logic [1:0] {
    P_DIV20,
    P_DIVA,
    P_MULA
  } gphase_t;

  gstate_t              state_r;
  gphase_t              phase_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [SIZE_BITS-1:0] req_r;
  logic [XW-1:0]        x_r;
  logic [PW-1:0]        acc_r;
  logic [ENTRY_W-1:0]   grown_r;

  logic [CH-1:0]        chunk;
  logic [KW-1:0]        kmul;
  logic [MW-1:0]        prod;
  logic [PW-1:0]        acc_nxt;
  logic [ENTRY_W-1:0]   adj;
  logic [ENTRY_W-1:0]   adj_pad;

  always_comb begin
    chunk = x_r[XW-1 -: CH];
    unique case (phase_r)
      P_DIV20: kmul = M1;
      P_DIVA:  kmul = M2;
      P_MULA:  kmul = ALIGN_K;
      default: kmul = '0;
    endcase
    prod    = MW'(chunk) * MW'(kmul);
    acc_nxt = (acc_r << CH) + PW'(prod);
    // req * 21 / 20 equals req + floor(req / 20).
    adj     = ENTRY_W'(req_r) + ENTRY_W'(acc_r >> SH1);
    adj_pad = adj + ALIGN_M1;
  end

  assign done  = (state_r == G_DONE);
  assign grown = grown_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= G_IDLE;
      phase_r <= P_DIV20;
      cnt_r   <= '0;
    end else if (start) begin
      state_r <= G_MUL;
      phase_r <= P_DIV20;
      cnt_r   <= LAST_CNT;
      req_r   <= req;
      x_r     <= XW'(req);
      acc_r   <= '0;
    end else begin
      unique case (state_r)
        G_IDLE: begin
        end
        G_MUL: begin
          acc_r <= acc_nxt;
          x_r   <= x_r << CH;
          if (cnt_r == '0) begin
            state_r <= G_STEP;
          end else begin
            cnt_r <= cnt_r - CNT_W'(1);
          end
        end
        G_STEP: begin
          unique case (phase_r)
            P_DIV20: begin
              x_r     <= XW'(adj_pad);
              acc_r   <= '0;
              cnt_r   <= LAST_CNT;
              phase_r <= P_DIVA;
              state_r <= G_MUL;
            end
            P_DIVA: begin
              x_r     <= XW'(acc_r >> SH2);
              acc_r   <= '0;
              cnt_r   <= LAST_CNT;
              phase_r <= P_MULA;
              state_r <= G_MUL;
            end
            P_MULA: begin
              grown_r <= ENTRY_W'(acc_r);
              state_r <= G_DONE;
            end
            default: begin
              state_r <= G_IDLE;
            end
          endcase
        end
        G_DONE: begin
        end
        default: begin
          state_r <= G_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/bfp_datapath.sv
module bfp_datapath #(
  parameter int POOL_ENTRIES = bfp_pkg::POOL_ENTRIES_DEF,
  parameter int SIZE_BITS    = bfp_pkg::SIZE_BITS_DEF,
  parameter int ALIGN_BYTES  = bfp_pkg::ALIGN_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  bfp_pkg::ctrl_cmd_t              cmd,
  output bfp_pkg::dp_status_t             sts,
  input  logic [bfp_pkg::REQ_W-1:0]       in_request_bytes,
  output logic [bfp_pkg::IDX_OUT_W-1:0]   out_entry_index,
  output logic [bfp_pkg::STATUS_W-1:0]    out_status,
  output logic [bfp_pkg::BYTES_OUT_W-1:0] out_entry_bytes,
  output logic [bfp_pkg::TOTAL_W-1:0]     out_total_bytes
);

  localparam int IDX_W       = $clog2(POOL_ENTRIES);
  localparam int CNT_W       = $clog2(POOL_ENTRIES + 1);
  localparam int ENTRY_W     = SIZE_BITS + 2;
  localparam int IDX_OUT_W   = bfp_pkg::IDX_OUT_W;
  localparam int BYTES_OUT_W = bfp_pkg::BYTES_OUT_W;
  localparam int TOTAL_W     = bfp_pkg::TOTAL_W;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(POOL_ENTRIES);

  logic [ENTRY_W-1:0]      size_mem [POOL_ENTRIES];
  logic [ENTRY_W-1:0]      rd_data_r;
  logic [POOL_ENTRIES-1:0] used_r;
  logic [CNT_W-1:0]        count_r;
  logic [TOTAL_W-1:0]      total_r;
  logic [SIZE_BITS-1:0]    req_r;
  logic [CNT_W-1:0]        rd_cnt_r;
  logic                    pend_r;
  logic [IDX_W-1:0]        pend_idx_r;
  logic                    stop_r;
  logic                    found_r;
  logic [IDX_W-1:0]        best_idx_r;
  logic [ENTRY_W-1:0]      best_diff_r;
  logic [ENTRY_W-1:0]      best_size_r;
  logic [IDX_OUT_W-1:0]    idx_out_r;
  bfp_pkg::status_t        status_out_r;
  logic [BYTES_OUT_W-1:0]  bytes_out_r;

  logic [SIZE_BITS-1:0]    req_in;
  logic [ENTRY_W-1:0]      req_ext;
  logic [ENTRY_W-1:0]      diff;
  logic                    issue;
  logic                    fits;
  logic                    better;
  logic                    grow_done;
  logic [ENTRY_W-1:0]      grown;
  logic                    append;

  bfp_grow #(
    .SIZE_BITS   (SIZE_BITS),
    .ALIGN_BYTES (ALIGN_BYTES),
    .ENTRY_W     (ENTRY_W)
  ) u_grow (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.start),
    .req   (req_in),
    .done  (grow_done),
    .grown (grown)
  );

  always_comb begin
    req_in  = SIZE_BITS'(in_request_bytes);
    req_ext = ENTRY_W'(req_r);
    diff    = rd_data_r - req_ext;
    issue   = (rd_cnt_r != count_r) && !stop_r;
    fits    = pend_r && !stop_r && !used_r[pend_idx_r] && (rd_data_r >= req_ext);
    better  = fits && (!found_r || (diff < best_diff_r));
    append  = cmd.commit && (cmd.kind == bfp_pkg::CMT_APPEND);
  end

  assign sts.scan_done = stop_r || ((rd_cnt_r == count_r) && !pend_r);
  assign sts.size_done = grow_done;
  assign sts.found     = found_r;
  assign sts.pool_full = (count_r == CNT_FULL);

  assign out_entry_index = idx_out_r;
  assign out_status      = status_out_r;
  assign out_entry_bytes = bytes_out_r;
  assign out_total_bytes = total_r;

  // Size table: one write port for appends, one registered read for the scan.
  always_ff @(posedge clk) begin
    if (append) begin
      size_mem[count_r[IDX_W-1:0]] <= grown;
    end
    rd_data_r <= size_mem[rd_cnt_r[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r   <= '0;
      count_r  <= '0;
      total_r  <= '0;
      rd_cnt_r <= '0;
      pend_r   <= 1'b0;
      stop_r   <= 1'b0;
      found_r  <= 1'b0;
    end else begin
      if (cmd.start) begin
        rd_cnt_r <= '0;
        pend_r   <= 1'b0;
        stop_r   <= 1'b0;
        found_r  <= 1'b0;
      end else begin
        if (issue) begin
          rd_cnt_r <= rd_cnt_r + CNT_W'(1);
        end
        pend_r <= issue;
        if (better) begin
          found_r <= 1'b1;
          if (diff == '0) begin
            stop_r <= 1'b1;
          end
        end
      end

      if (cmd.commit) begin
        unique case (cmd.kind)
          bfp_pkg::CMT_REUSE: begin
            used_r[best_idx_r] <= 1'b1;
          end
          bfp_pkg::CMT_APPEND: begin
            used_r[count_r[IDX_W-1:0]] <= 1'b1;
            count_r <= count_r + CNT_W'(1);
            total_r <= total_r + TOTAL_W'(grown);
          end
          bfp_pkg::CMT_RELEASE: begin
            used_r <= '0;
          end
          bfp_pkg::CMT_CLEAR: begin
            used_r  <= '0;
            count_r <= '0;
            total_r <= '0;
          end
          bfp_pkg::CMT_FULL, bfp_pkg::CMT_NONE: begin
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_r <= req_in;
    end
    pend_idx_r <= rd_cnt_r[IDX_W-1:0];
    if (better) begin
      best_idx_r  <= pend_idx_r;
      best_diff_r <= diff;
      best_size_r <= rd_data_r;
    end
    if (cmd.commit) begin
      unique case (cmd.kind)
        bfp_pkg::CMT_REUSE: begin
          idx_out_r    <= IDX_OUT_W'(best_idx_r);
          status_out_r <= bfp_pkg::ST_REUSED;
          bytes_out_r  <= BYTES_OUT_W'(best_size_r);
        end
        bfp_pkg::CMT_APPEND: begin
          idx_out_r    <= IDX_OUT_W'(count_r[IDX_W-1:0]);
          status_out_r <= bfp_pkg::ST_APPENDED;
          bytes_out_r  <= BYTES_OUT_W'(grown);
        end
        bfp_pkg::CMT_FULL: begin
          idx_out_r    <= '0;
          status_out_r <= bfp_pkg::ST_FULL;
          bytes_out_r  <= '0;
        end
        default: begin
          idx_out_r    <= '0;
          status_out_r <= bfp_pkg::ST_DONE;
          bytes_out_r  <= '0;
        end
      endcase
    end
  end

endmodule

### rtl/best_fit_buffer_pool.sv
// Best-fit buffer pool. Each input transaction on in_ch carries an operation
// (allocate, release all, clear) and a requested byte count; each one yields
// exactly one result transaction on out_ch with the granted entry index, a
// status code, the entry size and the running byte total of the pool.
// For an allocate, the size table is scanned one memory read per cycle and an
// exact fit ends the scan early, while a sizing unit works out the size of a
// possible new entry in three passes over a 16-bit slice multiplier. Release,
// clear and the unused code skip the search and go straight to the commit.
// Transactions are handled one at a time; a new one is accepted as soon as the
// previous result sits in the output register, even if it is still stalled.
// When out_ch.ready is low the result holds, and a following result waits
// inside the block until the output register is free.
// After reset the pool is empty: no entries, no used marks, total zero.
module best_fit_buffer_pool #(
  parameter int POOL_ENTRIES = bfp_pkg::POOL_ENTRIES_DEF,
  parameter int SIZE_BITS    = bfp_pkg::SIZE_BITS_DEF,
  parameter int ALIGN_BYTES  = bfp_pkg::ALIGN_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  bfp_in_if.sink      in_ch,
  bfp_out_if.source   out_ch
);

  // Command and status between the sequencing controller and the datapath.
  bfp_pkg::ctrl_cmd_t  cmd;
  bfp_pkg::dp_status_t sts;

  // The controller owns both handshakes. It starts the scan and the sizing
  // unit on an allocate, waits until both finish, then picks what to commit:
  // reuse the best-fitting free entry, append a new one, or report full.
  bfp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_op     (in_ch.operation),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // The datapath holds the size table, the used marks, the entry count and
  // the total, and the result register that drives the out_ch payload.
  bfp_datapath #(
    .POOL_ENTRIES (POOL_ENTRIES),
    .SIZE_BITS    (SIZE_BITS),
    .ALIGN_BYTES  (ALIGN_BYTES)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_request_bytes (in_ch.request_bytes),
    .out_entry_index  (out_ch.entry_index),
    .out_status       (out_ch.status),
    .out_entry_bytes  (out_ch.entry_bytes),
    .out_total_bytes  (out_ch.total_bytes)
  );

endmodule
